@@ rtl/wmsd_pkg.sv @@
package wmsd_pkg;

  localparam int ChanBits   = 10;
  localparam int Channels   = 1 << ChanBits;
  localparam int SlotBits   = 6;
  localparam int WindowMax  = 1 << SlotBits;
  localparam int SampleBits = 16;
  localparam int CountBits  = 7;
  localparam int SumBits    = SampleBits + SlotBits + 1;
  localparam int SqBits     = 2 * SampleBits + SlotBits;
  localparam int VarBits    = 2 * SumBits;
  localparam int RootBits   = VarBits / 2;
  localparam int StdBits    = 15;
  localparam int AddrBits   = ChanBits + SlotBits;

  typedef struct packed {
    logic clear;
    logic load;
    logic write_sample;
    logic clear_acc;
    logic accumulate;
    logic form_var;
    logic div_start;
    logic sqrt_start;
    logic finish;
  } wmsd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic sqrt_done;
    logic scan_last;
  } wmsd_status_t;

endpackage

@@ rtl/wmsd_ram.sv @@
module wmsd_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/wmsd_ctrl.sv @@
module wmsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wmsd_pkg::wmsd_status_t status,
  output wmsd_pkg::wmsd_cmd_t    cmd
);
  import wmsd_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_META  = 9'b0_0000_0100,
    S_WRITE = 9'b0_0000_1000,
    S_SCAN  = 9'b0_0001_0000,
    S_VAR   = 9'b0_0010_0000,
    S_DIV   = 9'b0_0100_0000,
    S_SQRT  = 9'b0_1000_0000,
    S_OUT   = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_META;
        end
      end
      S_META: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_sample = 1'b1;
        cmd.clear_acc = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.accumulate = 1'b1;
        if (status.scan_last) begin
          state_next = S_VAR;
        end
      end
      S_VAR: begin
        cmd.form_var = 1'b1;
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (status.sqrt_done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/wmsd_dp.sv @@
module wmsd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wmsd_pkg::CountBits-1:0]       cfg_data,
  input  logic [wmsd_pkg::ChanBits-1:0]        channel,
  input  logic signed [wmsd_pkg::SampleBits-1:0] sample,
  input  wmsd_pkg::wmsd_cmd_t                  cmd,
  output wmsd_pkg::wmsd_status_t               status,
  output logic [wmsd_pkg::ChanBits-1:0]        channel_out,
  output logic signed [wmsd_pkg::SampleBits-1:0] mean,
  output logic [wmsd_pkg::StdBits-1:0]         std_dev,
  output logic [wmsd_pkg::CountBits-1:0]       count_used
);
  import wmsd_pkg::*;

  localparam int MetaBits = CountBits + SlotBits;

  logic [CountBits-1:0] window_size;
  logic [CountBits-1:0] w_eff;
  logic [ChanBits-1:0]  chan;
  logic signed [SampleBits-1:0] x;

  // Per-channel fill count and write slot share one memory word. After reset
  // a clearing pass zeroes every word, one channel a cycle.
  logic [MetaBits-1:0]  meta_rd;
  logic [CountBits-1:0] fill, fill_new;
  logic [SlotBits-1:0]  slot, slot_new;
  logic [SlotBits:0]    slot_inc;
  logic [ChanBits-1:0]  clr_idx;
  logic                 meta_we;
  logic [ChanBits-1:0]  meta_waddr;
  logic [MetaBits-1:0]  meta_wdata;

  always_comb begin
    w_eff = window_size;
    if (window_size == '0) w_eff = CountBits'(1);
    if (window_size > CountBits'(WindowMax)) w_eff = CountBits'(WindowMax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CountBits'(16);
    end else if (cfg_we) begin
      window_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan <= channel;
      x    <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign status.clear_last = (clr_idx == '1);

  always_comb begin
    fill = meta_rd[MetaBits-1:SlotBits];
    slot = meta_rd[SlotBits-1:0];
    if (fill > w_eff) fill = w_eff;
    if ({1'b0, slot} >= w_eff) slot = '0;
    slot_inc = {1'b0, slot} + 1'b1;
    slot_new = (CountBits'(slot_inc) >= w_eff) ? '0 : slot;
    if (CountBits'(slot_inc) < w_eff) slot_new = slot_inc[SlotBits-1:0];
    fill_new = (fill < w_eff) ? fill + 1'b1 : fill;
  end

  assign meta_we    = cmd.write_sample | cmd.clear;
  assign meta_waddr = cmd.clear ? clr_idx : chan;
  assign meta_wdata = cmd.clear ? '0 : {fill_new, slot_new};

  wmsd_ram #(.Width(MetaBits), .Depth(Channels)) u_meta (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .raddr(chan),
    .rdata(meta_rd)
  );

  // Sample ring scan: one read address a cycle, with the data registered in the RAM and returned in the next cycle.
  logic [CountBits-1:0]  n;
  logic [CountBits-1:0]  rd_idx;
  logic [CountBits-1:0]  acc_idx;
  logic                  rd_live;
  logic [SampleBits-1:0] s_rd;
  logic [AddrBits-1:0]   raddr;

  assign raddr = {chan, rd_idx[SlotBits-1:0]};

  wmsd_ram #(.Width(SampleBits), .Depth(Channels * WindowMax)) u_store (
    .clk  (clk),
    .we   (cmd.write_sample),
    .waddr({chan, slot}),
    .wdata(x),
    .raddr(raddr),
    .rdata(s_rd)
  );

  logic signed [SumBits-1:0] sum;
  logic [SqBits-1:0]         sq;
  logic signed [SampleBits-1:0] s_val;
  logic [SampleBits-1:0]     s_abs;
  logic [2*SampleBits-1:0]   s_sq;

  assign s_val = s_rd;
  assign s_abs = s_val[SampleBits-1] ? SampleBits'(-s_val) : s_val;
  assign s_sq  = (2*SampleBits)'(s_abs) * (2*SampleBits)'(s_abs);
  assign status.scan_last = rd_live && (acc_idx + 1'b1 == n);

  always_ff @(posedge clk) begin
    if (cmd.write_sample) begin
      n       <= fill_new;
      rd_idx  <= '0;
      acc_idx <= '0;
      rd_live <= 1'b0;
    end else if (cmd.accumulate) begin
      rd_idx  <= rd_idx + 1'b1;
      rd_live <= 1'b1;
      if (rd_live) begin
        acc_idx <= acc_idx + 1'b1;
      end
    end
  end

  // Forwarding: the sample written this step is read in the same scan, but the
  // write lands before the first read address issues, so none is needed.
  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      sum <= '0;
      sq  <= '0;
    end else if (cmd.accumulate && rd_live) begin
      sum <= sum + SumBits'(s_val);
      sq  <= sq + SqBits'(s_sq);
    end
  end

  // Variance numerator n*Q - S*S and the divisor n*n.
  logic [SumBits-1:0]  asum;
  logic [VarBits-1:0]  num;
  logic [2*CountBits-1:0] nn;

  assign asum = sum[SumBits-1] ? SumBits'(-sum) : sum;

  always_ff @(posedge clk) begin
    if (cmd.form_var) begin
      num <= VarBits'(n) * VarBits'(sq) - VarBits'(asum) * VarBits'(asum);
      nn  <= (2*CountBits)'(n) * (2*CountBits)'(n);
    end
  end

  // Restoring divider, one quotient bit a cycle, shared by the mean and the
  // variance: first |S|/n, then num/nn.
  localparam int DivBits = VarBits;
  localparam int DivCntBits = $clog2(DivBits + 1);

  logic [DivBits-1:0]    dq;
  logic [DivBits-1:0]    dr;
  logic [DivBits-1:0]    dd;
  logic [DivCntBits-1:0] dcnt;
  logic                  dbusy;
  logic                  dphase;
  logic                  dpend;
  logic [DivBits:0]      dtrial;
  logic [SumBits-1:0]    mag_q;
  logic                  sum_neg;

  assign dtrial = {dr, dq[DivBits-1]} - {1'b0, dd};
  assign status.div_done = !dbusy && dphase;

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy  <= 1'b0;
      dphase <= 1'b0;
      dpend  <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy  <= 1'b1;
      dphase <= 1'b0;
      dpend  <= 1'b1;
      dq     <= DivBits'(asum);
      dd     <= DivBits'(n);
      dr     <= '0;
      dcnt   <= DivCntBits'(DivBits);
      sum_neg <= sum[SumBits-1];
    end else if (dbusy) begin
      if (dtrial[DivBits]) begin
        dr <= {dr[DivBits-2:0], dq[DivBits-1]};
        dq <= {dq[DivBits-2:0], 1'b0};
      end else begin
        dr <= dtrial[DivBits-1:0];
        dq <= {dq[DivBits-2:0], 1'b1};
      end
      dcnt <= dcnt - 1'b1;
      if (dcnt == DivCntBits'(1)) begin
        dbusy <= 1'b0;
      end
    end else if (dpend) begin
      // The mean quotient is done; keep it and start the variance divide.
      mag_q  <= dq[SumBits-1:0];
      dpend  <= 1'b0;
      dphase <= 1'b1;
      dbusy  <= 1'b1;
      dq     <= num;
      dd     <= DivBits'(nn);
      dr     <= '0;
      dcnt   <= DivCntBits'(DivBits);
    end else if (cmd.sqrt_start) begin
      dphase <= 1'b0;
    end
  end

  // Bit-pair integer square root, one result bit a cycle.
  localparam int SqCntBits = $clog2(RootBits + 1);

  logic [VarBits-1:0]   sv;
  logic [RootBits+1:0]  srem;
  logic [RootBits-1:0]  sroot;
  logic [SqCntBits-1:0] scnt;
  logic                 sbusy;
  logic                 sfin;
  logic [RootBits+1:0]  strial;

  assign strial = {srem[RootBits-1:0], sv[VarBits-1:VarBits-2]}
                  - {sroot, 2'b01};
  assign status.sqrt_done = sfin;

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sfin  <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sbusy <= 1'b1;
      sfin  <= 1'b0;
      sv    <= dq;
      srem  <= '0;
      sroot <= '0;
      scnt  <= SqCntBits'(RootBits);
    end else if (sbusy) begin
      sv <= {sv[VarBits-3:0], 2'b00};
      if (strial[RootBits+1]) begin
        srem  <= {srem[RootBits-1:0], sv[VarBits-1:VarBits-2]};
        sroot <= {sroot[RootBits-2:0], 1'b0};
      end else begin
        srem  <= strial;
        sroot <= {sroot[RootBits-2:0], 1'b1};
      end
      scnt <= scnt - 1'b1;
      if (scnt == SqCntBits'(1)) begin
        sbusy <= 1'b0;
        sfin  <= 1'b1;
      end
    end else begin
      sfin <= 1'b0;
    end
  end

  logic [SumBits-1:0] mean_s;
  assign mean_s = sum_neg ? SumBits'(-mag_q) : mag_q;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      channel_out <= chan;
      mean        <= mean_s[SampleBits-1:0];
      std_dev     <= (sroot > RootBits'(2**StdBits - 1)) ? '1 : sroot[StdBits-1:0];
      count_used  <= n;
    end
  end

endmodule

@@ rtl/windowed_mean_stddev_per_channel_unit.sv @@
// Windowed mean and population standard deviation, one ring of up to 64
// samples per channel for 1024 channels. Each accepted word writes its sample
// into the channel's ring and returns the truncated mean, the truncated
// standard deviation and the sample count of the window. After reset the
// block zeroes the per-channel fill counts and write slots of all 1024
// channels, with in_ready low. One word is in work at a time; its processing
// runs through the scan of the n stored samples in the window through the
// single sample-memory read port, the one-bit-a-cycle shared divider that
// runs twice, and the bit-a-cycle square root, and the result then waits for
// out_ready. window_size is to be written only while idle; the block itself
// does not enforce this. Changing it is meant to go together with a reset.
module windowed_mean_stddev_per_channel_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [wmsd_pkg::CountBits-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [wmsd_pkg::ChanBits-1:0]          channel,
  input  logic signed [wmsd_pkg::SampleBits-1:0] sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [wmsd_pkg::ChanBits-1:0]          channel_out,
  output logic signed [wmsd_pkg::SampleBits-1:0] mean,
  output logic [wmsd_pkg::StdBits-1:0]           std_dev,
  output logic [wmsd_pkg::CountBits-1:0]         count_used
);
  import wmsd_pkg::*;

  // The controller sequences the step; the datapath holds all storage.
  wmsd_cmd_t    cmd;
  wmsd_status_t status;

  wmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmsd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .channel    (channel),
    .sample     (sample),
    .cmd        (cmd),
    .status     (status),
    .channel_out(channel_out),
    .mean       (mean),
    .std_dev    (std_dev),
    .count_used (count_used)
  );

endmodule

@@ tb/sv/windowed_mean_stddev_per_channel_unit_checker.sv @@
module windowed_mean_stddev_per_channel_unit_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [wmsd_pkg::CountBits-1:0]         cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [wmsd_pkg::ChanBits-1:0]          channel,
  input  logic signed [wmsd_pkg::SampleBits-1:0] sample,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [wmsd_pkg::ChanBits-1:0]          channel_out,
  input  logic signed [wmsd_pkg::SampleBits-1:0] mean,
  input  logic [wmsd_pkg::StdBits-1:0]           std_dev,
  input  logic [wmsd_pkg::CountBits-1:0]         count_used,
  output int                                     errors,
  output int                                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wmsd_pkg::*;

  localparam int ExpDepth = 8;

  typedef struct packed {
    logic [ChanBits-1:0]          chan;
    logic signed [SampleBits-1:0] avg;
    logic [StdBits-1:0]           dev;
    logic [CountBits-1:0]         cnt;
  } stats_t;

  logic signed [SampleBits-1:0] ring_mem [Channels*WindowMax];
  logic [CountBits-1:0]         held     [Channels];
  logic [SlotBits-1:0]          next_pos [Channels];
  logic [CountBits-1:0]         win_reg;

  // Expected results wait here in order until the block hands them out.
  stats_t                       exp_buf [ExpDepth];
  logic [2:0]                   exp_wr;
  logic [2:0]                   exp_rd;
  int                           exp_cnt = 0;
  int                           err_cnt = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned root, probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  task automatic push_window_stats(input logic [ChanBits-1:0] ch,
                                   input logic signed [SampleBits-1:0] x);
    int              w, f, p, base, k;
    longint          total, avg;
    longint unsigned squares, mag, spread, dev;
    stats_t          e;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WindowMax) w = WindowMax;
    f = held[ch];
    p = next_pos[ch];
    if (f > w) f = w;
    if (p >= w) p = 0;
    base = ch * WindowMax;
    ring_mem[base + p] = x;
    p = (p + 1 >= w) ? 0 : p + 1;
    if (f < w) f++;
    held[ch]     = f[CountBits-1:0];
    next_pos[ch] = p[SlotBits-1:0];
    total   = 0;
    squares = 0;
    for (k = 0; k < f; k++) begin
      total   += longint'(ring_mem[base + k]);
      mag      = (ring_mem[base + k] < 0) ? -longint'(ring_mem[base + k])
                                          : longint'(ring_mem[base + k]);
      squares += mag * mag;
    end
    avg    = total / f;
    mag    = (total < 0) ? -total : total;
    spread = longint'(f) * squares - mag * mag;
    dev    = int_root(spread / (longint'(f) * f));
    if (dev > 32767) dev = 32767;
    e.chan = ch;
    e.avg  = avg[SampleBits-1:0];
    e.dev  = dev[StdBits-1:0];
    e.cnt  = f[CountBits-1:0];
    if (exp_cnt >= ExpDepth) begin
      err_cnt++;
      $display("%0t: more words in flight than expected, count %0d", $time, exp_cnt);
    end else begin
      exp_buf[exp_wr] = e;
      exp_wr = exp_wr + 3'd1;
      exp_cnt++;
    end
  endtask

  assign outstanding = exp_cnt;
  assign errors      = err_cnt;

  always @(posedge clk) begin
    stats_t e;
    if (rst) begin
      for (int i = 0; i < Channels; i++) begin
        held[i]     = '0;
        next_pos[i] = '0;
      end
      win_reg = 7'd16;
      exp_wr  = '0;
      exp_rd  = '0;
      exp_cnt = 0;
    end else begin
      if (cfg_we) win_reg = cfg_data;
      if (in_valid && in_ready) push_window_stats(channel, sample);
      if (out_valid && out_ready) begin
        if (exp_cnt == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word ch=%0d mean=%0d sd=%0d n=%0d",
                   $time, channel_out, mean, std_dev, count_used);
        end else begin
          e = exp_buf[exp_rd];
          exp_rd = exp_rd + 3'd1;
          exp_cnt--;
          if (channel_out !== e.chan) begin
            err_cnt++;
            $display("%0t: channel_out expected %0d actual %0d", $time, e.chan, channel_out);
          end
          if (mean !== e.avg) begin
            err_cnt++;
            $display("%0t: mean expected %0d actual %0d", $time, e.avg, mean);
          end
          if (std_dev !== e.dev) begin
            err_cnt++;
            $display("%0t: std_dev expected %0d actual %0d", $time, e.dev, std_dev);
          end
          if (count_used !== e.cnt) begin
            err_cnt++;
            $display("%0t: count_used expected %0d actual %0d", $time, e.cnt, count_used);
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/windowed_mean_stddev_per_channel_unit_tb.sv @@
module windowed_mean_stddev_per_channel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmsd_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 700;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CountBits-1:0]         cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ChanBits-1:0]          channel = '0;
  logic signed [SampleBits-1:0] sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ChanBits-1:0]          channel_out;
  logic signed [SampleBits-1:0] mean;
  logic [StdBits-1:0]           std_dev;
  logic [CountBits-1:0]         count_used;
  int                           errors;
  int                           outstanding;

  // Idle percentages for the two sides. The stimulus process raises hold_reqs
  // to ask for a long receiver hold; the receiver tracks what it has served.
  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycles    = 0;
  int words_sent = 0;

  windowed_mean_stddev_per_channel_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .channel_out(channel_out),
    .mean(mean), .std_dev(std_dev), .count_used(count_used)
  );

  windowed_mean_stddev_per_channel_unit_checker stats_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .channel_out(channel_out),
    .mean(mean), .std_dev(std_dev), .count_used(count_used),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // A runaway run is cut off here rather than hanging the simulator.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver decides its ready at each falling edge. A hold request is
  // served by this process alone, which counts the stalled cycles itself.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      out_ready  <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HoldCycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one word, optionally after idle cycles, and returns at the falling
  // edge after it was accepted. Valid is only lowered when an idle gap follows,
  // so back-to-back words keep it high.
  task automatic send_word(input logic [ChanBits-1:0] ch,
                           input logic signed [SampleBits-1:0] x);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    channel  = ch;
    sample   = x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // Lets the block drain completely, then writes the window size register.
  task automatic write_window(input logic [CountBits-1:0] w);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = w;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Window settings only ever shrink after the first write, so every slot in a
  // channel's window has been written since reset. The first value has all
  // bits set and acts as the largest window; the last value, zero, acts as one.
  logic [CountBits-1:0] window_plan [8] = '{7'd127, 7'd64, 7'd33, 7'd16,
                                            7'd7, 7'd2, 7'd1, 7'd0};

  initial begin
    logic [ChanBits-1:0]          pool [4];
    logic [ChanBits-1:0]          ch;
    logic signed [SampleBits-1:0] x;
    int                           pick, mode;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_window(window_plan[0]);

    // Directed words: sample extremes on the lowest and highest channel, a
    // constant window, a full-scale alternating window that pushes the
    // deviation to its largest value, and small negatives for truncation toward zero.
    send_word(10'd0, 16'sh7FFF);
    send_word(10'd0, 16'sh7FFF);
    send_word(10'd0, 16'sh7FFF);
    for (int i = 0; i < 8; i++) send_word(10'd1023, (i % 2) ? 16'sh7FFF : 16'sh8000);
    send_word(10'd5, -16'sd1);
    send_word(10'd5, 16'sd0);
    send_word(10'd5, -16'sd3);
    send_word(10'd6, 16'sh8000);
    send_word(10'd6, 16'sh8000);
    send_word(10'd7, 16'sd1);
    send_word(10'd7, -16'sd2);
    send_word(10'd512, 16'sh5555);
    send_word(10'd341, 16'shAAAA);
    send_word(10'd682, 16'sd0);

    for (int ph = 1; ph < 8; ph++) begin
      write_window(window_plan[ph]);
      mode = (ph - 1) * 3 / 7;
      send_idle = (mode == 0) ? 21 : (mode == 1) ? 84 : 0;
      recv_idle = (mode == 0) ? 84 : (mode == 1) ? 21 : 0;
      // A few busy channels per phase so windows fill up and wrap around.
      for (int i = 0; i < 4; i++) pool[i] = ChanBits'($urandom_range(1023));
      for (int n = 0; n < 115; n++) begin
        if (ph == 2 && n == 10) hold_reqs++;
        if (ph == 4 && n == 50) begin
          while (outstanding != 0) @(negedge clk);
        end
        ch = ($urandom_range(99) < 80) ? pool[$urandom_range(3)]
                                       : ChanBits'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 40) x = SampleBits'($urandom);
        else if (pick < 60) x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else if (pick < 80) x = SampleBits'(990 + int'($urandom_range(20)));
        else x = SampleBits'(int'($urandom_range(14)) - 7);
        send_word(ch, x);
      end
    end

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (250) @(negedge clk);

    $display("Sent %0d sample words over 8 window settings (1..64 and out of range),",
             words_sent);
    $display("with both sides idling, a long receiver hold and a full drain pause.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ windowed_mean_stddev_per_channel_unit.f @@
rtl/wmsd_pkg.sv
rtl/wmsd_ram.sv
rtl/wmsd_ctrl.sv
rtl/wmsd_dp.sv
rtl/windowed_mean_stddev_per_channel_unit.sv
tb/sv/windowed_mean_stddev_per_channel_unit_checker.sv
tb/sv/windowed_mean_stddev_per_channel_unit_tb.sv
